@@ rtl/sscd_pkg.sv @@
// shared types and constants for the scratchpad check and decode unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sscd_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned POS_W       = 4;

  // frame positions of the captured bytes
  localparam logic [POS_W-1:0] POS_TEMP_LOW   = 4'd0;
  localparam logic [POS_W-1:0] POS_TEMP_HIGH  = 4'd1;
  localparam logic [POS_W-1:0] POS_ALARM_HIGH = 4'd2;
  localparam logic [POS_W-1:0] POS_ALARM_LOW  = 4'd3;
  localparam logic [POS_W-1:0] POS_CONFIG     = 4'd4;
  localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_BYTES - 1);

  localparam logic [7:0] CRC_POLY = 8'h8C;

  // configuration byte codes
  localparam logic [7:0] CFG_9BIT  = 8'h1F;
  localparam logic [7:0] CFG_10BIT = 8'h3F;
  localparam logic [7:0] CFG_11BIT = 8'h5F;
  localparam logic [7:0] CFG_12BIT = 8'h7F;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_BAD_CFG = 2'd2
  } status_e;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/sscd_front.sv @@
// front part: accepts bytes and tags each with its frame position
// depends on sscd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sscd_front
  import sscd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  data_valid_i,
  input  wire logic  [7:0] data_byte_i,
  input  wire logic  frame_start_i,
  output logic       data_ready_o,
  output logic       push_valid_o,
  output item_t      push_item_o,
  input  wire logic  push_ready_i
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] pos_cur;
  logic             accept;

  assign data_ready_o = push_ready_i;
  assign push_valid_o = data_valid_i;
  assign accept       = data_valid_i & push_ready_i;

  // frame start resyncs to byte 0
  assign pos_cur = frame_start_i ? POS_TEMP_LOW : pos_q;

  assign push_item_o = '{data: data_byte_i, pos: pos_cur};

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (pos_cur == POS_LAST) begin
        pos_d = POS_TEMP_LOW;
      end else begin
        pos_d = pos_cur + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sscd_fifo.sv @@
// short register queue between front and back
// depends on sscd_pkg for the item type
`timescale 1ns / 1ps
`default_nettype none

module sscd_fifo
  import sscd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  item_t      in_item_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output item_t      out_item_o,
  input  wire logic  out_ready_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = (count_q != CNT_W'(DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    count_d = count_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sscd_back.sv @@
// back part: crc update, byte capture and result register
// depends on sscd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sscd_back
  import sscd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         item_valid_i,
  input  item_t             item_i,
  output logic              item_ready_o,
  output logic              result_valid_o,
  input  wire logic         result_ready_i,
  output logic       [1:0]  status_o,
  output logic signed [15:0] temperature_o,
  output logic       [1:0]  resolution_code_o,
  output logic       [7:0]  high_alarm_o,
  output logic       [7:0]  low_alarm_o
);

  function automatic logic [7:0] crc_step(logic [7:0] crc, logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  logic [7:0] crc_q, crc_d, crc_in;
  logic [7:0] temp_low_q, temp_high_q, alarm_high_q, alarm_low_q, config_q;
  logic       out_valid_q, out_valid_d;
  logic       last, pop, cfg_known;
  logic [1:0] code;
  logic [15:0] raw, mask;
  status_e    status_d, status_q;
  logic [15:0] temp_d, temp_q;
  logic [1:0] code_d, code_q;

  assign last         = (item_i.pos == POS_LAST);
  assign item_ready_o = !last || !out_valid_q || result_ready_i;
  assign pop          = item_valid_i & item_ready_o;

  assign crc_in = (item_i.pos == POS_TEMP_LOW) ? 8'h00 : crc_q;
  assign crc_d  = crc_step(crc_in, item_i.data);

  always_comb begin
    cfg_known = 1'b1;
    case (config_q)
      CFG_9BIT:  code = 2'd0;
      CFG_10BIT: code = 2'd1;
      CFG_11BIT: code = 2'd2;
      CFG_12BIT: code = 2'd3;
      default: begin
        code      = 2'd0;
        cfg_known = 1'b0;
      end
    endcase
  end

  // drop the bits below the configured resolution
  assign raw  = {temp_high_q, temp_low_q};
  assign mask = 16'hFFFF << (~code);

  always_comb begin
    if (crc_d != 8'h00) begin
      status_d = STATUS_CRC_ERR;
      temp_d   = '0;
      code_d   = '0;
    end else if (!cfg_known) begin
      status_d = STATUS_BAD_CFG;
      temp_d   = '0;
      code_d   = '0;
    end else begin
      status_d = STATUS_OK;
      temp_d   = raw & mask;
      code_d   = code;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && result_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop && last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q        <= '0;
      temp_low_q   <= '0;
      temp_high_q  <= '0;
      alarm_high_q <= '0;
      alarm_low_q  <= '0;
      config_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        crc_q <= last ? 8'h00 : crc_d;
        case (item_i.pos)
          POS_TEMP_LOW:   temp_low_q   <= item_i.data;
          POS_TEMP_HIGH:  temp_high_q  <= item_i.data;
          POS_ALARM_HIGH: alarm_high_q <= item_i.data;
          POS_ALARM_LOW:  alarm_low_q  <= item_i.data;
          POS_CONFIG:     config_q     <= item_i.data;
          default: ;
        endcase
      end
    end
  end

  // result payload, loaded only with the last byte of a frame
  always_ff @(posedge clk_i) begin
    if (pop && last) begin
      status_q      <= status_d;
      temp_q        <= temp_d;
      code_q        <= code_d;
      high_alarm_o  <= alarm_high_q;
      low_alarm_o   <= alarm_low_q;
    end
  end

  assign result_valid_o    = out_valid_q;
  assign status_o          = status_q;
  assign temperature_o     = signed'(temp_q);
  assign resolution_code_o = code_q;

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop && last))
    else $error("result raised without a last byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_ready_i) |-> !(pop && last))
    else $error("pending result overwritten");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != STATUS_OK)) |-> (temp_q == '0 && code_q == '0))
    else $error("error result carries temperature or code");

endmodule

`default_nettype wire

@@ rtl/sensor_scratchpad_check_decode_unit.sv @@
// top level of the scratchpad check and decode unit
// depends on sscd_pkg, sscd_front, sscd_fifo, sscd_back
//
// usage: scratchpad bytes enter on the data channel (data_valid_i,
// data_ready_o, data_byte_i, frame_start_i), one byte per accepted item.
// frame_start_i marks byte 0 of a frame and drops any partial frame.
// after the ninth byte one result appears on the result channel
// (result_valid_o, result_ready_i) with status, temperature, resolution
// code and both alarm bytes; other bytes give no result.
// throughput: one byte per cycle, set by the crc and capture step in the
// back part, unless a held result stalls the back part (see below).
// the ninth byte is first written into the queue; the result register
// loads as it leaves the queue, and result_valid_o rises with that load.
// reset clears the frame position, crc, captured bytes and all valid flags.
// when the receiver stalls the result register holds; bytes keep flowing
// into the back part until the next ninth byte meets the held result, then
// the FIFO_DEPTH entry queue fills and data_ready_o falls.
`timescale 1ns / 1ps
`default_nettype none

module sensor_scratchpad_check_decode_unit
  import sscd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          data_valid_i,
  output logic               data_ready_o,
  input  wire logic   [7:0]  data_byte_i,
  input  wire logic          frame_start_i,
  output logic               result_valid_o,
  input  wire logic          result_ready_i,
  output logic        [1:0]  status_o,
  output logic signed [15:0] temperature_o,
  output logic        [1:0]  resolution_code_o,
  output logic        [7:0]  high_alarm_o,
  output logic        [7:0]  low_alarm_o
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  sscd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_valid_i  (data_valid_i),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .data_ready_o  (data_ready_o),
    .push_valid_o  (push_valid),
    .push_item_o   (push_item),
    .push_ready_i  (push_ready)
  );

  sscd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push_valid),
    .in_item_i   (push_item),
    .in_ready_o  (push_ready),
    .out_valid_o (pop_valid),
    .out_item_o  (pop_item),
    .out_ready_i (pop_ready)
  );

  sscd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (pop_valid),
    .item_i            (pop_item),
    .item_ready_o      (pop_ready),
    .result_valid_o    (result_valid_o),
    .result_ready_i    (result_ready_i),
    .status_o          (status_o),
    .temperature_o     (temperature_o),
    .resolution_code_o (resolution_code_o),
    .high_alarm_o      (high_alarm_o),
    .low_alarm_o       (low_alarm_o)
  );

endmodule

`default_nettype wire
